// ===== design/esl_pkg.sv =====
// ----------------------------------------------------------------------------
// esl_pkg: shared types and constants for the emergency slot light controller
// Item, result and configuration structs, operation and state codes.
// ----------------------------------------------------------------------------
package esl_pkg;

  localparam int SLOT_COUNT_DEF = 4;

  localparam int POLE_ID_W   = 16;
  localparam int MS_CFG_W    = 20;
  localparam int CFG_DATA_W  = 20;
  localparam int CFG_INDEX_W = 2;
  localparam int TIME_W      = 32;
  localparam int EID_W       = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_POLE_ID = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_HB_TOUT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_HOLD    = 2'd2;

  localparam logic [MS_CFG_W-1:0] HB_TIMEOUT_RST  = 20'd45000;
  localparam logic [MS_CFG_W-1:0] PASSED_HOLD_RST = 20'd5000;

  typedef enum logic {
    OP_UPDATE  = 1'b0,
    OP_COMMAND = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CMD_ENGAGE  = 2'd0,
    CMD_PREWARN = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_CANCEL  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    LM_OFF       = 2'd0,
    LM_DIM       = 2'd1,
    LM_MOTION    = 2'd2,
    LM_EMERGENCY = 2'd3
  } light_mode_t;

  typedef enum logic [2:0] {
    PS_NORMAL    = 3'd0,
    PS_PREPARING = 3'd1,
    PS_ACTIVE    = 3'd2,
    PS_PASSED    = 3'd3,
    PS_FAULT     = 3'd4,
    PS_OFFLINE   = 3'd5
  } pole_state_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_DECODE,
    FSM_SCAN,
    FSM_CHECK,
    FSM_HOLD,
    FSM_DONE
  } fsm_t;

  typedef struct packed {
    logic [POLE_ID_W-1:0] pole_id;
    logic [MS_CFG_W-1:0]  heartbeat_timeout_ms;
    logic [MS_CFG_W-1:0]  passed_hold_ms;
  } cfg_t;

  typedef struct packed {
    op_t                  operation;
    logic [TIME_W-1:0]    now_ms;
    logic                 is_dark;
    logic                 motion;
    logic [POLE_ID_W-1:0] target_id;
    logic                 target_broadcast;
    cmd_t                 command;
    logic [EID_W-1:0]     emergency_id;
  } item_t;

  typedef struct packed {
    logic        light_write;
    light_mode_t light_mode;
    logic        strobe_clear;
    pole_state_t pole_state;
    logic [2:0]  active_slots;
    logic        slot_timed_out;
  } result_t;

  typedef struct packed {
    logic eq;
    logic gt;
  } alu_res_t;

endpackage

// ===== design/esl_if.sv =====
// ----------------------------------------------------------------------------
// esl_in_if / esl_out_if: valid/ready channels of the slot light controller
// Input item channel and result channel with their payload fields.
// ----------------------------------------------------------------------------
interface esl_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] now_ms;
  logic        is_dark;
  logic        motion;
  logic [15:0] target_id;
  logic        target_broadcast;
  logic [1:0]  command;
  logic [31:0] emergency_id;
  logic [2:0]  priority_req;

  modport source (
    output valid, operation, now_ms, is_dark, motion, target_id,
           target_broadcast, command, emergency_id, priority_req,
    input  ready
  );
  modport sink (
    input  valid, operation, now_ms, is_dark, motion, target_id,
           target_broadcast, command, emergency_id, priority_req,
    output ready
  );
endinterface

interface esl_out_if;
  logic       valid;
  logic       ready;
  logic       light_write;
  logic [1:0] light_mode;
  logic       strobe_clear;
  logic [2:0] pole_state;
  logic [2:0] active_slots;
  logic       slot_timed_out;

  modport source (
    output valid, light_write, light_mode, strobe_clear, pole_state,
           active_slots, slot_timed_out,
    input  ready
  );
  modport sink (
    input  valid, light_write, light_mode, strobe_clear, pole_state,
           active_slots, slot_timed_out,
    output ready
  );
endinterface

// ===== design/emergency_slot_light_mode_controller_core.sv =====
// ----------------------------------------------------------------------------
// emergency_slot_light_mode_controller_core: street-light pole controller
// Configuration registers, item intake, sequencer and result register.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+--------------------------------
//  in_if    | sink      | valid / ready    | update or command item
//  out_if   | source    | valid / ready    | one result beat per item
//  cfg_*    | sink      | cfg_we, no wait  | register index and write data
//
//  Steps: DECODE, DONE for prepare or an unaddressed command; DECODE, SCAN
//  to a free or matching slot or the last, DONE for activate; DECODE, SCAN of
//  all slots, CHECK, DONE for deactivate or cancel, with HOLD before DONE for
//  an update. SCAN walks one slot a cycle. in_if.ready rises with out_if.valid.
//  A waiting result stalls the sequencer in its last step only if the next
//  result is done too. Reset is synchronous: pole NORMAL, slots free.
// ----------------------------------------------------------------------------
module emergency_slot_light_mode_controller_core #(
  parameter int SLOT_COUNT = esl_pkg::SLOT_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  esl_in_if.sink                             in_if,
  esl_out_if.source                          out_if,
  input  logic                               cfg_we,
  input  logic [esl_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [esl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import esl_pkg::*;

  cfg_t    cfg_r;
  item_t   item;
  logic    item_load;
  logic    idle;
  logic    res_valid;
  logic    res_ready;
  result_t res;
  logic    out_valid_r;
  result_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pole_id              <= '0;
      cfg_r.heartbeat_timeout_ms <= HB_TIMEOUT_RST;
      cfg_r.passed_hold_ms       <= PASSED_HOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_POLE_ID: cfg_r.pole_id              <= cfg_wdata[POLE_ID_W-1:0];
        CFG_IDX_HB_TOUT: cfg_r.heartbeat_timeout_ms <= cfg_wdata[MS_CFG_W-1:0];
        CFG_IDX_HOLD:    cfg_r.passed_hold_ms       <= cfg_wdata[MS_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign item.operation        = op_t'(in_if.operation);
  assign item.now_ms           = in_if.now_ms;
  assign item.is_dark          = in_if.is_dark;
  assign item.motion           = in_if.motion;
  assign item.target_id        = in_if.target_id;
  assign item.target_broadcast = in_if.target_broadcast;
  assign item.command          = cmd_t'(in_if.command);
  assign item.emergency_id     = in_if.emergency_id;

  assign in_if.ready = idle;
  assign item_load   = in_if.valid && idle;

  esl_ctrl #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .item      (item),
    .item_load (item_load),
    .idle      (idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // hold the result beat until the sink takes it
  assign res_ready = !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.light_write    = out_data_r.light_write;
  assign out_if.light_mode     = out_data_r.light_mode;
  assign out_if.strobe_clear   = out_data_r.strobe_clear;
  assign out_if.pole_state     = out_data_r.pole_state;
  assign out_if.active_slots   = out_data_r.active_slots;
  assign out_if.slot_timed_out = out_data_r.slot_timed_out;

endmodule

// ===== design/esl_alu.sv =====
// ----------------------------------------------------------------------------
// esl_alu: shared subtract and compare unit
// Wrapping difference a - b tested against a limit, and equality of a and b.
// ----------------------------------------------------------------------------
module esl_alu (
  input  logic [31:0]           op_a,
  input  logic [31:0]           op_b,
  input  logic [19:0]           limit,
  output esl_pkg::alu_res_t     res
);
  import esl_pkg::*;

  logic [31:0] diff;

  assign diff   = op_a - op_b;
  assign res.eq = (op_a == op_b);
  assign res.gt = (diff > {12'd0, limit});

endmodule

// ===== design/esl_ctrl.sv =====
// ----------------------------------------------------------------------------
// esl_ctrl: sequencer, pole state and emergency slot store
// Walks the slots one per cycle through the shared compare unit, then
// settles the pole state and the light mode for the item.
// ----------------------------------------------------------------------------
module esl_ctrl #(
  parameter int SLOT_COUNT = esl_pkg::SLOT_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  esl_pkg::cfg_t     cfg,
  input  esl_pkg::item_t    item,
  input  logic              item_load,
  output logic              idle,
  output logic              res_valid,
  input  logic              res_ready,
  output esl_pkg::result_t  res
);
  import esl_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  fsm_t                  fsm_r, fsm_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  item_t                 item_r;
  pole_state_t           pole_r, pole_nxt;
  logic [TIME_W-1:0]     entered_r, entered_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  wr_r, wr_nxt;
  light_mode_t           mode_r, mode_nxt;
  logic                  strobe_r, strobe_nxt;
  logic                  tout_r, tout_nxt;

  // The priority level of a slot never reaches a result, so it is not kept.
  logic [SLOT_COUNT-1:0] slot_valid_r;
  logic [EID_W-1:0]      slot_eid_r [SLOT_COUNT];
  logic [TIME_W-1:0]     slot_hb_r  [SLOT_COUNT];

  logic                  slot_set;
  logic                  slot_clr;
  logic                  enter_req;
  pole_state_t           enter_code;
  logic                  addressed;
  logic                  last;
  logic                  cur_valid;

  logic [31:0]           alu_a;
  logic [31:0]           alu_b;
  logic [19:0]           alu_lim;
  alu_res_t              alu_res;
  logic [31:0]           cnt_ext;

  esl_alu u_alu (
    .op_a  (alu_a),
    .op_b  (alu_b),
    .limit (alu_lim),
    .res   (alu_res)
  );

  assign addressed = item_r.target_broadcast || (item_r.target_id == cfg.pole_id);
  assign last      = (idx_r == LAST_IDX);
  assign cur_valid = slot_valid_r[idx_r];
  assign idle      = (fsm_r == FSM_IDLE);
  assign cnt_ext   = 32'(cnt_r);

  always_comb begin
    fsm_nxt     = fsm_r;
    idx_nxt     = idx_r;
    pole_nxt    = pole_r;
    entered_nxt = entered_r;
    cnt_nxt     = cnt_r;
    wr_nxt      = wr_r;
    mode_nxt    = mode_r;
    strobe_nxt  = strobe_r;
    tout_nxt    = tout_r;
    slot_set    = 1'b0;
    slot_clr    = 1'b0;
    enter_req   = 1'b0;
    enter_code  = PS_NORMAL;
    res_valid   = 1'b0;
    alu_a       = item_r.emergency_id;
    alu_b       = slot_eid_r[idx_r];
    alu_lim     = cfg.heartbeat_timeout_ms;

    case (fsm_r)
      FSM_IDLE: begin
        if (item_load) begin
          fsm_nxt    = FSM_DECODE;
          idx_nxt    = '0;
          wr_nxt     = 1'b0;
          mode_nxt   = LM_OFF;
          strobe_nxt = 1'b0;
          tout_nxt   = 1'b0;
        end
      end
      FSM_DECODE: begin
        if (item_r.operation == OP_UPDATE) begin
          fsm_nxt = FSM_SCAN;
        end else if (!addressed) begin
          fsm_nxt = FSM_DONE;
        end else if (item_r.command == CMD_PREWARN) begin
          if (pole_r != PS_ACTIVE) begin
            enter_req  = 1'b1;
            enter_code = PS_PREPARING;
          end
          fsm_nxt = FSM_DONE;
        end else begin
          fsm_nxt = FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        if (item_r.operation == OP_UPDATE) begin
          alu_a = item_r.now_ms;
          alu_b = slot_hb_r[idx_r];
          // expire a stale slot
          if (cur_valid && alu_res.gt) begin
            slot_clr = 1'b1;
            cnt_nxt  = cnt_r - CNT_W'(1);
            tout_nxt = 1'b1;
          end
          if (last) begin
            fsm_nxt = FSM_CHECK;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end else if (item_r.command == CMD_ENGAGE) begin
          // take the first slot that is free or already holds the ID
          if (!cur_valid || alu_res.eq) begin
            slot_set   = 1'b1;
            if (!cur_valid) begin
              cnt_nxt = cnt_r + CNT_W'(1);
            end
            enter_req  = 1'b1;
            enter_code = PS_ACTIVE;
            fsm_nxt    = FSM_DONE;
          end else if (last) begin
            enter_req  = 1'b1;
            enter_code = PS_ACTIVE;
            fsm_nxt    = FSM_DONE;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end else begin
          if (cur_valid && alu_res.eq) begin
            slot_clr = 1'b1;
            cnt_nxt  = cnt_r - CNT_W'(1);
          end
          if (last) begin
            fsm_nxt = FSM_CHECK;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      FSM_CHECK: begin
        if ((item_r.operation == OP_COMMAND || tout_r) &&
            cnt_r == '0 && pole_r == PS_ACTIVE) begin
          enter_req  = 1'b1;
          enter_code = PS_PASSED;
        end
        fsm_nxt = (item_r.operation == OP_UPDATE) ? FSM_HOLD : FSM_DONE;
      end
      FSM_HOLD: begin
        alu_a   = item_r.now_ms;
        alu_b   = entered_r;
        alu_lim = cfg.passed_hold_ms;
        if (pole_r == PS_PASSED) begin
          if (alu_res.gt) begin
            enter_req  = 1'b1;
            enter_code = PS_NORMAL;
          end
        end else if (pole_r == PS_NORMAL) begin
          wr_nxt = 1'b1;
          if (!item_r.is_dark) begin
            mode_nxt = LM_OFF;
          end else if (item_r.motion) begin
            mode_nxt = LM_MOTION;
          end else begin
            mode_nxt = LM_DIM;
          end
        end
        fsm_nxt = FSM_DONE;
      end
      FSM_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          fsm_nxt = FSM_IDLE;
        end
      end
      default: begin
        fsm_nxt = FSM_IDLE;
      end
    endcase

    if (enter_req) begin
      pole_nxt    = enter_code;
      entered_nxt = item_r.now_ms;
      case (enter_code)
        PS_ACTIVE: begin
          wr_nxt   = 1'b1;
          mode_nxt = LM_EMERGENCY;
        end
        PS_PREPARING: begin
          wr_nxt   = 1'b1;
          mode_nxt = LM_DIM;
        end
        PS_PASSED, PS_NORMAL: begin
          strobe_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r        <= FSM_IDLE;
      pole_r       <= PS_NORMAL;
      entered_r    <= '0;
      cnt_r        <= '0;
      slot_valid_r <= '0;
    end else begin
      fsm_r     <= fsm_nxt;
      pole_r    <= pole_nxt;
      entered_r <= entered_nxt;
      cnt_r     <= cnt_nxt;
      if (slot_set) begin
        slot_valid_r[idx_r] <= 1'b1;
      end else if (slot_clr) begin
        slot_valid_r[idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    wr_r     <= wr_nxt;
    mode_r   <= mode_nxt;
    strobe_r <= strobe_nxt;
    tout_r   <= tout_nxt;
    if (item_load) begin
      item_r <= item;
    end
    if (slot_set) begin
      slot_eid_r[idx_r] <= item_r.emergency_id;
      slot_hb_r[idx_r]  <= item_r.now_ms;
    end
  end

  assign res.light_write    = wr_r;
  assign res.light_mode     = mode_r;
  assign res.strobe_clear   = strobe_r;
  assign res.pole_state     = pole_r;
  assign res.active_slots   = cnt_ext[2:0];
  assign res.slot_timed_out = tout_r;

endmodule
